[rtl/slw_pkg.sv]
package slw_pkg;

    // history and tap geometry
    localparam int HISTORY_DEPTH = 256;
    localparam int MAX_TAPS      = 64;
    localparam int DATA_W        = 64;

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);        // cell position
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);    // rows seen, lag offset
    localparam int BACK_W = CNT_W + 1;                    // offset plus tap
    localparam int TAP_W  = 6;                            // tap_index field
    localparam int TCNT_W = 7;                            // tap_count register

    // read tree: cells are OR-combined in groups, then the groups
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = (HISTORY_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    // configuration port
    localparam int CFG_DATA_W = 9;

    typedef enum logic [0:0] {
        CFG_LAG_OFFSET = 1'b0,
        CFG_TAP_COUNT  = 1'b1
    } t_cfg_idx;

    // per-result side information that travels down the read pipeline
    typedef struct packed {
        logic [DATA_W-1:0] dflt;
        logic              from_default;
        logic [TAP_W-1:0]  tap_index;
        logic              row_last;
        logic              batch_end;
    } t_tap_meta;

    // one tap read issued by the sequencer
    typedef struct packed {
        logic             valid;
        logic [PTR_W-1:0] rd_idx;
        t_tap_meta        meta;
    } t_issue;

    // sequencer status seen by the top level
    typedef struct packed {
        logic             busy;
        logic             last;
        logic [TAP_W-1:0] tap;
        logic [CNT_W-1:0] rows_seen;
    } t_seq_status;

endpackage

[rtl/stream_lag_window.sv]
// Lag window over a row stream. Every accepted row gives tap_count results in
// order: result i carries the value seen lag_offset+i rows before this row, or
// the row's own default when that row has not yet arrived (from_default set).
// History is a row of 256 cells that shift by one place per stored row; the
// cell of the requested age is picked by a two-level registered OR tree, so a
// result passes the group registers and then the output register. While the
// output is not held, the block issues one tap per cycle and single-tap rows
// flow one per cycle; the single read of the cell row per cycle sets that
// rate. A window reaching past 256 rows is cut at the oldest entry. No
// clearing pass runs after reset; the block takes rows from the first cycle
// out of reset.
module stream_lag_window (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [0:0]                        i_cfg_idx,
    input  logic [slw_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // row input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [127:0]                      s_axis_tdata,  // value, dflt
    input  logic                              s_axis_tlast,  // batch_end
    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [71:0]                       m_axis_tdata,  // lagged_value, tap_index, pad
    output logic                              m_axis_tlast,  // row_last
    output logic [1:0]                        m_axis_tuser   // from_default, batch_end_out
);
    import slw_pkg::*;

    logic [CNT_W-1:0]  r_lag_offset;
    logic [TCNT_W-1:0] r_tap_count;

    t_issue            issue;
    t_seq_status       status;
    logic              adv;
    logic              shift;
    logic [DATA_W-1:0] shift_data;
    logic [DATA_W-1:0] cell_data [HISTORY_DEPTH];
    logic [DATA_W-1:0] cell_sel  [HISTORY_DEPTH];
    logic [DATA_W-1:0] out_value;
    t_tap_meta         out_meta;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_offset <= CNT_W'(1);
            r_tap_count  <= TCNT_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LAG_OFFSET: r_lag_offset <= i_cfg_wdata[CNT_W-1:0];
                CFG_TAP_COUNT:  r_tap_count  <= i_cfg_wdata[TCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // row sequencer: holds one row and issues its taps
    slw_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_value      (s_axis_tdata[DATA_W-1:0]),
        .i_dflt       (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .i_batch_end  (s_axis_tlast),
        .i_lag_offset (r_lag_offset),
        .i_tap_count  (r_tap_count),
        .i_adv        (adv),
        .o_issue      (issue),
        .o_shift      (shift),
        .o_shift_data (shift_data),
        .o_status     (status)
    );

    // history cells, newest first
    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            slw_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (shift),
                .i_data   (shift_data),
                .i_pos    (PTR_W'(k)),
                .i_rd_idx (issue.rd_idx),
                .o_data   (cell_data[k]),
                .o_sel    (cell_sel[k])
            );
        end else begin : g_body
            slw_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (shift),
                .i_data   (cell_data[k-1]),
                .i_pos    (PTR_W'(k)),
                .i_rd_idx (issue.rd_idx),
                .o_data   (cell_data[k]),
                .o_sel    (cell_sel[k])
            );
        end
    end

    // read tree and output register
    slw_read_tree u_tree (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_cell_sel  (cell_sel),
        .i_out_ready (m_axis_tready),
        .o_adv       (adv),
        .o_valid     (m_axis_tvalid),
        .o_value     (out_value),
        .o_meta      (out_meta)
    );

    assign m_axis_tdata = {2'b00, out_meta.tap_index, out_value};
    assign m_axis_tlast = out_meta.row_last;
    assign m_axis_tuser = {out_meta.batch_end, out_meta.from_default};

    // a new row is taken only when no tap of the held row is left
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!status.busy || (status.last && adv)))
        else $error("row accepted while taps of the held row remain");

    // an accepted row starts at its nearest tap
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (status.busy && status.tap == '0))
        else $error("row did not start at tap zero");

    // the row count never runs past the history depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.rows_seen <= CNT_W'(HISTORY_DEPTH))
        else $error("rows seen exceeds history depth");

    // the batch marker only appears on a row's final result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("batch end on a result that is not the row's last");

endmodule

[rtl/slw_cell.sv]
module slw_cell (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [slw_pkg::DATA_W-1:0] i_data,
    input  logic [slw_pkg::PTR_W-1:0]  i_pos,
    input  logic [slw_pkg::PTR_W-1:0]  i_rd_idx,
    output logic [slw_pkg::DATA_W-1:0] o_data,
    output logic [slw_pkg::DATA_W-1:0] o_sel
);
    import slw_pkg::*;

    logic [DATA_W-1:0] r_data;

    // one history entry; moves one place older on every stored row
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

    // drive the read bus only when this cell is the requested age
    assign o_sel = (i_pos == i_rd_idx) ? r_data : '0;

endmodule

[rtl/slw_seq.sv]
module slw_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input row
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [slw_pkg::DATA_W-1:0]     i_value,
    input  logic [slw_pkg::DATA_W-1:0]     i_dflt,
    input  logic                           i_batch_end,
    // configuration
    input  logic [slw_pkg::CNT_W-1:0]      i_lag_offset,
    input  logic [slw_pkg::TCNT_W-1:0]     i_tap_count,
    // pipeline
    input  logic                           i_adv,
    output slw_pkg::t_issue                o_issue,
    output logic                           o_shift,
    output logic [slw_pkg::DATA_W-1:0]     o_shift_data,
    output slw_pkg::t_seq_status           o_status
);
    import slw_pkg::*;

    logic                r_busy;
    logic [TAP_W-1:0]    r_tap;
    logic [CNT_W-1:0]    r_rows_seen;
    logic [DATA_W-1:0]   r_val;
    logic [DATA_W-1:0]   r_dflt;
    logic                r_bend;
    logic [CNT_W-1:0]    r_off;
    logic [TCNT_W-1:0]   r_taps;

    logic [CNT_W-1:0]    off_eff;
    logic [TCNT_W-1:0]   taps_sat;
    logic [CNT_W-1:0]    room;
    logic [TCNT_W-1:0]   taps_eff;
    logic [BACK_W-1:0]   back;
    logic                last;
    logic                fire;
    logic                accept;

    // clamp the configured window to what the history can hold
    always_comb begin
        if (i_lag_offset == '0) begin
            off_eff = CNT_W'(1);
        end else if (i_lag_offset > CNT_W'(HISTORY_DEPTH)) begin
            off_eff = CNT_W'(HISTORY_DEPTH);
        end else begin
            off_eff = i_lag_offset;
        end

        if (i_tap_count == '0) begin
            taps_sat = TCNT_W'(1);
        end else if (i_tap_count > TCNT_W'(MAX_TAPS)) begin
            taps_sat = TCNT_W'(MAX_TAPS);
        end else begin
            taps_sat = i_tap_count;
        end

        room = CNT_W'(HISTORY_DEPTH + 1) - off_eff;
        if ({{(CNT_W-TCNT_W){1'b0}}, taps_sat} > room) begin
            taps_eff = room[TCNT_W-1:0];
        end else begin
            taps_eff = taps_sat;
        end
    end

    // current tap of the row being worked
    assign back   = {1'b0, r_off} + BACK_W'(r_tap);
    assign last   = ({1'b0, r_tap} + TCNT_W'(1)) == r_taps;
    assign fire   = r_busy && i_adv;
    assign o_ready = !r_busy || (fire && last);
    assign accept = i_valid && o_ready;

    always_comb begin
        o_issue.valid             = r_busy;
        o_issue.rd_idx            = PTR_W'(back - BACK_W'(1));
        o_issue.meta.dflt         = r_dflt;
        o_issue.meta.from_default = back > {1'b0, r_rows_seen};
        o_issue.meta.tap_index    = r_tap;
        o_issue.meta.row_last     = last;
        o_issue.meta.batch_end    = last && r_bend;
    end

    // the row's value enters the cell row once its last tap is read
    assign o_shift      = fire && last;
    assign o_shift_data = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_tap       <= '0;
            r_rows_seen <= '0;
        end else begin
            if (o_shift && (r_rows_seen != CNT_W'(HISTORY_DEPTH))) begin
                r_rows_seen <= r_rows_seen + CNT_W'(1);
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_tap  <= '0;
            end else if (fire) begin
                if (last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_tap <= r_tap + TAP_W'(1);
                end
            end
        end
    end

    // row payload, held for all of its taps
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val  <= i_value;
            r_dflt <= i_dflt;
            r_bend <= i_batch_end;
            r_off  <= off_eff;
            r_taps <= taps_eff;
        end
    end

    always_comb begin
        o_status.busy      = r_busy;
        o_status.last      = last;
        o_status.tap       = r_tap;
        o_status.rows_seen = r_rows_seen;
    end

endmodule

[rtl/slw_read_tree.sv]
module slw_read_tree (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  slw_pkg::t_issue            i_issue,
    input  logic [slw_pkg::DATA_W-1:0] i_cell_sel [slw_pkg::HISTORY_DEPTH],
    input  logic                       i_out_ready,
    output logic                       o_adv,
    output logic                       o_valid,
    output logic [slw_pkg::DATA_W-1:0] o_value,
    output slw_pkg::t_tap_meta         o_meta
);
    import slw_pkg::*;

    logic [DATA_W-1:0] r_grp [NUM_GROUPS];
    logic              r_s1_valid;
    t_tap_meta         r_s1_meta;
    logic              r_s2_valid;
    t_tap_meta         r_s2_meta;
    logic [DATA_W-1:0] r_s2_value;

    logic [DATA_W-1:0] n_grp [NUM_GROUPS];
    logic [DATA_W-1:0] n_all;

    // whole pipeline moves unless the output register is held
    assign o_adv = !r_s2_valid || i_out_ready;

    // first level: OR of each group of cells
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_grp[g] = '0;
            for (int c = 0; c < GROUP_SIZE; c++) begin
                if (g * GROUP_SIZE + c < HISTORY_DEPTH) begin
                    n_grp[g] = n_grp[g] | i_cell_sel[g * GROUP_SIZE + c];
                end
            end
        end
    end

    // second level: OR of the groups
    always_comb begin
        n_all = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_all = n_all | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (o_adv) begin
            r_s1_valid <= i_issue.valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_grp      <= n_grp;
            r_s1_meta  <= i_issue.meta;
            r_s2_meta  <= r_s1_meta;
            r_s2_value <= r_s1_meta.from_default ? r_s1_meta.dflt : n_all;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_value = r_s2_value;
    assign o_meta  = r_s2_meta;

endmodule

[test/lag_window_checker.sv]
`timescale 1ns / 100ps

module lag_window_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_idx,
    input  logic [slw_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // row channel
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [127:0]                   i_s_tdata,   // value, dflt
    input  logic                           i_s_tlast,   // batch_end
    // result channel
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [71:0]                    i_m_tdata,   // lagged_value, tap_index, pad
    input  logic                           i_m_tlast,   // row_last
    input  logic [1:0]                     i_m_tuser,   // from_default, batch_end_out
    output int                             o_fail_count,
    output int                             o_pending
);
    import slw_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] lagged_value;
        logic              from_default;
        logic [TAP_W-1:0]  tap_index;
        logic              row_last;
        logic              batch_end;
    } t_lag_result;

    t_lag_result       lag_results_q[$];
    logic [DATA_W-1:0] past_rows [HISTORY_DEPTH];
    int                next_slot;
    int                stored_rows;
    logic [8:0]        lag_offset_reg;
    logic [6:0]        tap_count_reg;
    int                fail_count = 0;

    // expected taps for one row, then the row enters the history
    task automatic predict_lag_taps(input logic [DATA_W-1:0] value,
                                    input logic [DATA_W-1:0] dflt,
                                    input logic              bend);
        int          first_back;
        int          n_taps;
        int          back;
        int          t;
        t_lag_result res;
        first_back = lag_offset_reg;
        if (first_back < 1) first_back = 1;
        if (first_back > HISTORY_DEPTH) first_back = HISTORY_DEPTH;
        n_taps = tap_count_reg;
        if (n_taps < 1) n_taps = 1;
        if (n_taps > MAX_TAPS) n_taps = MAX_TAPS;
        // window cut at the oldest stored row
        if (first_back + n_taps - 1 > HISTORY_DEPTH) n_taps = HISTORY_DEPTH - first_back + 1;
        for (t = 0; t < n_taps; t++) begin
            back = first_back + t;
            if (back <= stored_rows) begin
                res.lagged_value = past_rows[(next_slot + HISTORY_DEPTH - back) % HISTORY_DEPTH];
                res.from_default = 1'b0;
            end else begin
                res.lagged_value = dflt;
                res.from_default = 1'b1;
            end
            res.tap_index = t[TAP_W-1:0];
            res.row_last  = (t == n_taps - 1);
            res.batch_end = res.row_last & bend;
            lag_results_q.insert(lag_results_q.size(), res);
        end
        past_rows[next_slot] = value;
        next_slot = (next_slot + 1) % HISTORY_DEPTH;
        if (stored_rows < HISTORY_DEPTH) stored_rows++;
    endtask

    // track config, predict on row transactions, compare on result transactions
    always @(posedge i_clk) begin
        t_lag_result got;
        t_lag_result want;
        if (!i_rst_n) begin
            lag_results_q.delete();
            next_slot      = 0;
            stored_rows    = 0;
            lag_offset_reg = 9'd1;
            tap_count_reg  = 7'd1;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LAG_OFFSET: lag_offset_reg = i_cfg_wdata[8:0];
                    CFG_TAP_COUNT:  tap_count_reg  = i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_lag_taps(i_s_tdata[63:0], i_s_tdata[127:64], i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.lagged_value = i_m_tdata[63:0];
                got.tap_index    = i_m_tdata[69:64];
                got.row_last     = i_m_tlast;
                got.from_default = i_m_tuser[0];
                got.batch_end    = i_m_tuser[1];
                if (lag_results_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result value %h tap %0d", $realtime,
                                 got.lagged_value, got.tap_index);
                end else begin
                    want = lag_results_q[0];
                    lag_results_q.delete(0);
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: exp %h/%b/%0d/%b/%b got %h/%b/%0d/%b/%b",
                                     $realtime, want.lagged_value, want.from_default,
                                     want.tap_index, want.row_last, want.batch_end,
                                     got.lagged_value, got.from_default, got.tap_index,
                                     got.row_last, got.batch_end);
                    end
                end
            end
        end
        o_pending    <= lag_results_q.size();
        o_fail_count <= fail_count;
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
    import slw_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 20;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [0:0]            cfg_idx     = CFG_LAG_OFFSET;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [127:0]          s_tdata     = '0;
    logic                  s_tlast     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [71:0]           m_tdata;
    logic                  m_tlast;
    logic [1:0]            m_tuser;

    int fail_count;
    int pending;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    stream_lag_window i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .m_axis_tuser  (m_tuser)
    );

    lag_window_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            m_tready     <= 1'b0;
            hold_left    <= LONG_HOLD;
            holds_served <= hold_requests;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // both registers, back to back, block idle
    task automatic write_config(input logic [8:0] lag, input logic [8:0] taps);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_LAG_OFFSET;
        cfg_wdata <= lag;
        @(posedge clk);
        cfg_idx   <= CFG_TAP_COUNT;
        cfg_wdata <= taps;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one row transaction; tvalid stays high when no gap follows
    task automatic send_row(input logic [63:0] value, input logic [63:0] dflt,
                            input logic bend);
        int gap;
        s_tdata  <= {dflt, value};
        s_tlast  <= bend;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_row();
        send_row(rand_word(), rand_word(), $urandom_range(3) == 0);
    endtask

    // stop offering rows and wait for every outstanding result
    task automatic stop_and_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic run_phase(input logic [8:0] lag, input logic [8:0] taps,
                             input int idle, input int stall, input int rows,
                             input bit with_hold, input bit with_pause);
        int r;
        stop_and_drain();
        idle_pct   = idle;
        stall_pct <= stall;
        write_config(lag, taps);
        for (r = 0; r < rows; r++) begin
            if (with_hold && r == 3) hold_requests <= hold_requests + 1;
            if (with_pause && r == rows / 2) stop_and_drain();
            send_random_row();
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero offset and zero tap count, field extremes
        write_config(9'd0, 9'd0);
        send_row(64'h0, '1, 1'b0);
        send_row('1, 64'h0, 1'b1);
        send_row(64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1);
        send_row(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0);
        // short multi-tap window
        run_phase(9'd2, 9'd3, 0, 0, 4, 1'b0, 1'b0);
        // offset and tap count above range
        run_phase(9'd511, 9'd127, 0, 0, 3, 1'b0, 1'b0);
        // window past the history, high wdata bits on tap count
        run_phase(9'd250, 9'h1C0, 0, 0, 3, 1'b0, 1'b0);
        // full tap count
        run_phase(9'd1, 9'd64, 0, 0, 3, 1'b0, 1'b0);
        run_phase(9'd2, 9'd100, 0, 0, 2, 1'b0, 1'b0);

        // random rows over several settings and idling mixes
        run_phase(9'd1, 9'd1, 0, 0, 15, 1'b1, 1'b0);
        run_phase(9'($urandom_range(1, 8)), 9'($urandom_range(1, 4)), 59, 0, 12,
                  1'b0, 1'b0);
        run_phase(9'd3, 9'd8, 0, 59, 12, 1'b0, 1'b0);
        run_phase(9'($urandom_range(100, 200)), 9'd2, 14, 14, 12, 1'b0, 1'b0);
        run_phase(9'd1, 9'd1, 0, 0, 14, 1'b0, 1'b1);
        run_phase(9'd256, 9'd1, 14, 14, 8, 1'b0, 1'b0);
        run_phase(9'd193, 9'd64, 0, 59, 3, 1'b0, 1'b0);
        run_phase(9'($urandom_range(0, 511)), 9'($urandom_range(0, 127)), 14, 14, 8,
                  1'b0, 1'b0);

        stop_and_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
